// ===== rtl/qft_pkg.sv =====
// Shared types and constants for the two-axis rotation to quaternion pipeline.
// Used by the channel interfaces and every module of the block. No dependencies.
package qft_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int P0_W     = 2 * IN_W;
    localparam int C2_W     = P0_W + 1;
    localparam int P2_W     = C2_W + IN_W;
    localparam int C1_W     = P2_W + 1;
    localparam int Q_W      = 50;
    localparam int MAG_W    = Q_W - 1;
    localparam int NORM_TOP = 29;
    localparam int M_W      = NORM_TOP + 1;
    localparam int SQ_W     = 2 * M_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int FRAC_W   = 14;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int NUM_W    = M_W + QUO_W;
    localparam int POS_W    = 6;

    localparam int FRONT_ST = 5;
    localparam int NORM_ST  = 5;
    localparam int ROOT_ST  = ROOT_W + 1;
    localparam int DIV_ST   = QUO_W + 2;

    localparam logic signed [OUT_W-1:0] UNIT_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [IN_W-1:0] first_axis_x;
        logic signed [IN_W-1:0] first_axis_y;
        logic signed [IN_W-1:0] first_axis_z;
        logic signed [IN_W-1:0] second_axis_x;
        logic signed [IN_W-1:0] second_axis_y;
        logic signed [IN_W-1:0] second_axis_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic signed [OUT_W-1:0] quat_w;
        logic                    identity_fallback;
    } t_out_item;

    typedef struct packed {
        logic [3:0][M_W-1:0] m;
        logic [3:0]          neg;
        logic                zero;
    } t_side;

endpackage

// ===== rtl/qft_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on qft_pkg for the payload types.
interface qft_in_if import qft_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface qft_out_if import qft_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/qft_front.sv =====
// Front pipeline: cross products for the columns and branch selection that forms the
// unnormalized quaternion. Depends on qft_pkg.
module qft_front import qft_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_item            i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [Q_W-1:0] o_q [4]
);

    localparam int E_W = Q_W + 2;

    logic [FRONT_ST-1:0] r_v;
    logic [FRONT_ST-1:0] w_en;
    logic [FRONT_ST-1:0] n_v;

    logic signed [IN_W-1:0] r_a_s0 [3];
    logic signed [IN_W-1:0] r_a_s1 [3];
    logic signed [IN_W-1:0] r_a_s2 [3];
    logic signed [IN_W-1:0] r_a_s3 [3];
    logic signed [P0_W-1:0] r_p0 [6];
    logic signed [C2_W-1:0] r_c2_s1 [3];
    logic signed [C2_W-1:0] r_c2_s2 [3];
    logic signed [C2_W-1:0] r_c2_s3 [3];
    logic signed [P2_W-1:0] r_p2 [6];
    logic signed [C1_W-1:0] r_c1 [3];
    logic signed [Q_W-1:0]  r_q [4];
    logic signed [Q_W-1:0]  n_q [4];

    always_comb begin
        w_en[FRONT_ST-1] = !r_v[FRONT_ST-1] || i_ready;
        for (int k = FRONT_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign n_v     = {r_v[FRONT_ST-2:0], i_valid};
    assign o_ready = w_en[0];
    assign o_valid = r_v[FRONT_ST-1];
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < FRONT_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_comb begin
        logic signed [E_W-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z, one;
        c0x = E_W'(r_a_s3[0]) <<< 24;
        c0y = E_W'(r_a_s3[1]) <<< 24;
        c0z = E_W'(r_a_s3[2]) <<< 24;
        c1x = E_W'(r_c1[0]);
        c1y = E_W'(r_c1[1]);
        c1z = E_W'(r_c1[2]);
        c2x = E_W'(r_c2_s3[0]) <<< 12;
        c2y = E_W'(r_c2_s3[1]) <<< 12;
        c2z = E_W'(r_c2_s3[2]) <<< 12;
        one = E_W'(1) <<< 36;
        if (r_c2_s3[2][C2_W-1]) begin
            if (c0x > c1y) begin
                n_q[0] = Q_W'(one + c0x - c1y - c2z);
                n_q[1] = Q_W'(c0y + c1x);
                n_q[2] = Q_W'(c2x + c0z);
                n_q[3] = Q_W'(c1z - c2y);
            end else begin
                n_q[0] = Q_W'(c0y + c1x);
                n_q[1] = Q_W'(one - c0x + c1y - c2z);
                n_q[2] = Q_W'(c1z + c2y);
                n_q[3] = Q_W'(c2x - c0z);
            end
        end else begin
            if (c0x < -c1y) begin
                n_q[0] = Q_W'(c2x + c0z);
                n_q[1] = Q_W'(c1z + c2y);
                n_q[2] = Q_W'(one - c0x - c1y + c2z);
                n_q[3] = Q_W'(c0y - c1x);
            end else begin
                n_q[0] = Q_W'(c1z - c2y);
                n_q[1] = Q_W'(c2x - c0z);
                n_q[2] = Q_W'(c0y - c1x);
                n_q[3] = Q_W'(one + c0x + c1y + c2z);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p0[0]   <= i_item.first_axis_y * i_item.second_axis_z;
            r_p0[1]   <= i_item.first_axis_z * i_item.second_axis_y;
            r_p0[2]   <= i_item.first_axis_z * i_item.second_axis_x;
            r_p0[3]   <= i_item.first_axis_x * i_item.second_axis_z;
            r_p0[4]   <= i_item.first_axis_x * i_item.second_axis_y;
            r_p0[5]   <= i_item.first_axis_y * i_item.second_axis_x;
            r_a_s0[0] <= i_item.first_axis_x;
            r_a_s0[1] <= i_item.first_axis_y;
            r_a_s0[2] <= i_item.first_axis_z;
        end
        if (w_en[1]) begin
            r_c2_s1[0] <= C2_W'(r_p0[0]) - C2_W'(r_p0[1]);
            r_c2_s1[1] <= C2_W'(r_p0[2]) - C2_W'(r_p0[3]);
            r_c2_s1[2] <= C2_W'(r_p0[4]) - C2_W'(r_p0[5]);
            r_a_s1     <= r_a_s0;
        end
        if (w_en[2]) begin
            r_p2[0] <= r_c2_s1[1] * r_a_s1[2];
            r_p2[1] <= r_c2_s1[2] * r_a_s1[1];
            r_p2[2] <= r_c2_s1[2] * r_a_s1[0];
            r_p2[3] <= r_c2_s1[0] * r_a_s1[2];
            r_p2[4] <= r_c2_s1[0] * r_a_s1[1];
            r_p2[5] <= r_c2_s1[1] * r_a_s1[0];
            r_c2_s2 <= r_c2_s1;
            r_a_s2  <= r_a_s1;
        end
        if (w_en[3]) begin
            r_c1[0] <= C1_W'(r_p2[0]) - C1_W'(r_p2[1]);
            r_c1[1] <= C1_W'(r_p2[2]) - C1_W'(r_p2[3]);
            r_c1[2] <= C1_W'(r_p2[4]) - C1_W'(r_p2[5]);
            r_c2_s3 <= r_c2_s2;
            r_a_s3  <= r_a_s2;
        end
        if (w_en[4]) begin
            r_q <= n_q;
        end
    end

endmodule

// ===== rtl/qft_norm.sv =====
// Normalization front: magnitudes, common block shift to a 30-bit mantissa, squares and
// their sum. Depends on qft_pkg.
module qft_norm import qft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [Q_W-1:0] i_q [4],
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [SUM_W-1:0]      o_sum,
    output t_side                 o_side
);

    localparam int SH_W = MAG_W + NORM_TOP;

    logic [NORM_ST-1:0] r_v;
    logic [NORM_ST-1:0] w_en;
    logic [NORM_ST-1:0] n_v;

    logic [MAG_W-1:0] r_mag0 [4];
    logic [MAG_W-1:0] n_mag [4];
    logic [3:0]       r_neg0;
    logic [MAG_W-1:0] r_or0;
    logic [MAG_W-1:0] n_or;
    logic [MAG_W-1:0] r_mag1 [4];
    logic [3:0]       r_neg1;
    logic [POS_W-1:0] r_pos1;
    logic             r_zero1;
    t_side            r_side2;
    t_side            n_side2;
    t_side            r_side3;
    t_side            r_side4;
    logic [SQ_W-1:0]  r_sq3 [4];
    logic [SUM_W-1:0] r_sum4;

    function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    always_comb begin
        w_en[NORM_ST-1] = !r_v[NORM_ST-1] || i_ready;
        for (int k = NORM_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign n_v     = {r_v[NORM_ST-2:0], i_valid};
    assign o_ready = w_en[0];
    assign o_valid = r_v[NORM_ST-1];
    assign o_sum   = r_sum4;
    assign o_side  = r_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NORM_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_comb begin
        n_or = '0;
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = i_q[i][Q_W-1] ? MAG_W'(-i_q[i]) : MAG_W'(i_q[i]);
            n_or     = n_or | n_mag[i];
        end
    end

    // The leading one of the largest magnitude moves to bit NORM_TOP; low bits drop.
    always_comb begin
        logic [SH_W-1:0] wide;
        n_side2.neg  = r_neg1;
        n_side2.zero = r_zero1;
        for (int i = 0; i < 4; i++) begin
            wide         = {r_mag1[i], {NORM_TOP{1'b0}}} >> r_pos1;
            n_side2.m[i] = wide[M_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mag0 <= n_mag;
            r_or0  <= n_or;
            for (int i = 0; i < 4; i++) begin
                r_neg0[i] <= i_q[i][Q_W-1];
            end
        end
        if (w_en[1]) begin
            r_mag1  <= r_mag0;
            r_neg1  <= r_neg0;
            r_pos1  <= lead_pos(r_or0);
            r_zero1 <= (r_or0 == '0);
        end
        if (w_en[2]) begin
            r_side2 <= n_side2;
        end
        if (w_en[3]) begin
            for (int i = 0; i < 4; i++) begin
                r_sq3[i] <= r_side2.m[i] * r_side2.m[i];
            end
            r_side3 <= r_side2;
        end
        if (w_en[4]) begin
            r_sum4  <= SUM_W'(r_sq3[0]) + SUM_W'(r_sq3[1]) + SUM_W'(r_sq3[2])
                     + SUM_W'(r_sq3[3]);
            r_side4 <= r_side3;
        end
    end

endmodule

// ===== rtl/qft_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data carried
// alongside. Depends on qft_pkg.
module qft_isqrt import qft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_sum,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_len,
    output t_side             o_side
);

    localparam int D_W = SUM_W + 2;

    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_root_st;

    logic [ROOT_ST-1:0] r_v;
    logic [ROOT_ST-1:0] w_en;
    logic [ROOT_ST-1:0] n_v;
    t_root_st           r_st [ROOT_ST];
    t_root_st           n_st [ROOT_ST];

    always_comb begin
        w_en[ROOT_ST-1] = !r_v[ROOT_ST-1] || i_ready;
        for (int k = ROOT_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign n_v     = {r_v[ROOT_ST-2:0], i_valid};
    assign o_ready = w_en[0];
    assign o_valid = r_v[ROOT_ST-1];
    assign o_len   = r_st[ROOT_ST-1].root;
    assign o_side  = r_st[ROOT_ST-1].side;

    assign n_st[0] = '{rem: i_sum, root: '0, side: i_side};

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;
        always_comb begin
            logic [D_W-1:0] trial;
            trial     = (D_W'(r_st[k].root) << (B + 1)) | (D_W'(1) << (2 * B));
            n_st[k+1] = r_st[k];
            if (D_W'(r_st[k].rem) >= trial) begin
                n_st[k+1].rem  = r_st[k].rem - SUM_W'(trial);
                n_st[k+1].root = r_st[k].root | (ROOT_W'(1) << B);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_ST; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < ROOT_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

endmodule

// ===== rtl/qft_div.sv =====
// Four-lane pipelined restoring divider producing rounded Q1.14 components, plus the
// output register with sign and identity handling. Depends on qft_pkg.
module qft_div import qft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ROOT_W-1:0] i_len,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_item         o_item
);

    typedef struct packed {
        logic [3:0][NUM_W-1:0] rem;
        logic [3:0][QUO_W-1:0] quo;
        logic [ROOT_W-1:0]     len;
        logic [3:0]            neg;
        logic                  zero;
    } t_div_st;

    logic [DIV_ST-1:0] r_v;
    logic [DIV_ST-1:0] w_en;
    logic [DIV_ST-1:0] n_v;
    t_div_st           r_st [QUO_W+1];
    t_div_st           n_st [QUO_W+1];
    t_out_item         r_out;
    t_out_item         n_out;

    always_comb begin
        w_en[DIV_ST-1] = !r_v[DIV_ST-1] || i_ready;
        for (int k = DIV_ST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign n_v     = {r_v[DIV_ST-2:0], i_valid};
    assign o_ready = w_en[0];
    assign o_valid = r_v[DIV_ST-1];
    assign o_item  = r_out;

    always_comb begin
        n_st[0].len  = i_len;
        n_st[0].neg  = i_side.neg;
        n_st[0].zero = i_side.zero;
        n_st[0].quo  = '0;
        for (int i = 0; i < 4; i++) begin
            n_st[0].rem[i] = (NUM_W'(i_side.m[i]) << FRAC_W) + NUM_W'(i_len >> 1);
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int B = QUO_W - 1 - k;
        always_comb begin
            logic [NUM_W-1:0] dv;
            dv        = NUM_W'(r_st[k].len) << B;
            n_st[k+1] = r_st[k];
            for (int i = 0; i < 4; i++) begin
                if (r_st[k].rem[i] >= dv) begin
                    n_st[k+1].rem[i]    = r_st[k].rem[i] - dv;
                    n_st[k+1].quo[i][B] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        logic signed [OUT_W-1:0] v [4];
        for (int i = 0; i < 4; i++) begin
            v[i] = r_st[QUO_W].neg[i] ? -OUT_W'(r_st[QUO_W].quo[i])
                                      : OUT_W'(r_st[QUO_W].quo[i]);
        end
        if (r_st[QUO_W].zero) begin
            n_out = '{quat_x: '0, quat_y: '0, quat_z: '0, quat_w: UNIT_Q14,
                      identity_fallback: 1'b1};
        end else begin
            n_out = '{quat_x: v[0], quat_y: v[1], quat_z: v[2], quat_w: v[3],
                      identity_fallback: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QUO_W; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (w_en[DIV_ST-1]) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < DIV_ST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    a_identity_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.identity_fallback |->
            o_item.quat_x == 0 && o_item.quat_y == 0 && o_item.quat_z == 0 &&
            o_item.quat_w == UNIT_Q14)
        else $error("identity transaction carries wrong components");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_item.quat_x <= UNIT_Q14 && o_item.quat_x >= -UNIT_Q14 &&
            o_item.quat_y <= UNIT_Q14 && o_item.quat_y >= -UNIT_Q14 &&
            o_item.quat_z <= UNIT_Q14 && o_item.quat_z >= -UNIT_Q14 &&
            o_item.quat_w <= UNIT_Q14 && o_item.quat_w >= -UNIT_Q14)
        else $error("quaternion component exceeds unit magnitude");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== rtl/quat_from_two_axis_rotation.sv =====
// Top level of the two-axis rotation to unit quaternion converter.
// Depends on qft_pkg, qft_if, qft_front, qft_norm, qft_isqrt and qft_div.
//
// Usage:
// The input channel i_in carries one bone rotation per transaction: two axis vectors
// in signed Q3.12. The result channel o_out carries the normalized quaternion in
// signed Q1.14 and a flag that is set when the quaternion had zero length and the
// identity was returned instead. Both channels are valid/ready; a transaction
// completes on a clock edge where both are high.
// Each transaction yields exactly one result transaction, in order. The pipeline is
// 59 register stages deep, and a new input is accepted every cycle while the
// receiver does not stall. Most of the depth comes from the square root
// (one root bit per stage) and the four-lane divider (one quotient bit per stage).
// Every stage holds its own valid bit, so when the receiver stalls, empty stages
// still fill and input is taken until the pipeline is full; nothing is dropped.
// Synchronous reset empties the pipeline; the block holds no other state.
module quat_from_two_axis_rotation import qft_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qft_in_if.sink        i_in,
    qft_out_if.source     o_out
);

    logic                  w_f_valid, w_f_ready;
    logic signed [Q_W-1:0] w_f_q [4];
    logic                  w_n_valid, w_n_ready;
    logic [SUM_W-1:0]      w_n_sum;
    t_side                 w_n_side;
    logic                  w_r_valid, w_r_ready;
    logic [ROOT_W-1:0]     w_r_len;
    t_side                 w_r_side;

    qft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.payload),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_q     (w_f_q)
    );

    qft_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_q     (w_f_q),
        .o_valid (w_n_valid),
        .i_ready (w_n_ready),
        .o_sum   (w_n_sum),
        .o_side  (w_n_side)
    );

    qft_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_n_valid),
        .o_ready (w_n_ready),
        .i_sum   (w_n_sum),
        .i_side  (w_n_side),
        .o_valid (w_r_valid),
        .i_ready (w_r_ready),
        .o_len   (w_r_len),
        .o_side  (w_r_side)
    );

    qft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r_valid),
        .o_ready (w_r_ready),
        .i_len   (w_r_len),
        .i_side  (w_r_side),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.payload)
    );

endmodule

// ===== tb/quat_from_two_axis_rotation_test.sv =====
// Testbench for quat_from_two_axis_rotation: drives rotation transactions, predicts
// each quaternion in fixed point and compares results in order.
// Depends on qft_pkg, qft_if and the RTL of the block.
`timescale 1ns / 100ps

module quat_from_two_axis_rotation_test;
    import qft_pkg::*;

    logic i_clk;
    logic i_rst_n;
    qft_in_if  in_ch ();
    qft_out_if out_ch ();

    quat_from_two_axis_rotation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_in_item  pending_rot[$];
    t_out_item expected_quat[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        stim_done = 0;
    bit        hold_send = 0;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_out_item predict_quat(input t_in_item it);
        longint ax, ay, az, bx, by, bz;
        longint c2x, c2y, c2z, c1x, c1y, c1z;
        longint k0x, k0y, k0z, k2x, k2y, k2z;
        longint q[4];
        logic [63:0] mag[4];
        bit neg[4];
        logic [63:0] mx, s, len, v;
        longint one36;
        t_out_item r;
        ax = it.first_axis_x;  ay = it.first_axis_y;  az = it.first_axis_z;
        bx = it.second_axis_x; by = it.second_axis_y; bz = it.second_axis_z;
        one36 = 64'sd1 << 36;
        c2x = ay * bz - az * by;
        c2y = az * bx - ax * bz;
        c2z = ax * by - ay * bx;
        c1x = c2y * az - c2z * ay;
        c1y = c2z * ax - c2x * az;
        c1z = c2x * ay - c2y * ax;
        k0x = ax * 16777216; k0y = ay * 16777216; k0z = az * 16777216;
        k2x = c2x * 4096; k2y = c2y * 4096; k2z = c2z * 4096;
        if (c2z < 0) begin
            if (k0x > c1y) begin
                q[0] = one36 + k0x - c1y - k2z; q[1] = k0y + c1x;
                q[2] = k2x + k0z;               q[3] = c1z - k2y;
            end else begin
                q[0] = k0y + c1x;               q[1] = one36 - k0x + c1y - k2z;
                q[2] = c1z + k2y;               q[3] = k2x - k0z;
            end
        end else begin
            if (k0x < -c1y) begin
                q[0] = k2x + k0z;               q[1] = c1z + k2y;
                q[2] = one36 - k0x - c1y + k2z; q[3] = k0y - c1x;
            end else begin
                q[0] = c1z - k2y;               q[1] = k2x - k0z;
                q[2] = k0y - c1x;               q[3] = one36 + k0x + c1y + k2z;
            end
        end
        mx = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = q[i] < 0;
            mag[i] = neg[i] ? -q[i] : q[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            r.quat_x = 0; r.quat_y = 0; r.quat_z = 0; r.quat_w = UNIT_Q14;
            r.identity_fallback = 1'b1;
            return r;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
        end
        s = 0;
        for (int i = 0; i < 4; i++) s = s + mag[i] * mag[i];
        len = isqrt(s);
        for (int i = 0; i < 4; i++) begin
            v = (mag[i] * 64'd16384 + (len >> 1)) / len;
            if (neg[i]) v = -v;
            case (i)
                0: r.quat_x = v[15:0];
                1: r.quat_y = v[15:0];
                2: r.quat_z = v[15:0];
                default: r.quat_w = v[15:0];
            endcase
        end
        r.identity_fallback = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8191) - 4096);
            2: return 16'($urandom_range(0, 15) - 8);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'h1000;
                    default: return 16'hf000;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item make_rot(input logic [15:0] a0, a1, a2, b0, b1, b2);
        t_in_item it;
        it.first_axis_x = a0;  it.first_axis_y = a1;  it.first_axis_z = a2;
        it.second_axis_x = b0; it.second_axis_y = b1; it.second_axis_z = b2;
        return it;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_quat.push_back(predict_quat(in_ch.payload));
            end
            if (pending_rot.size() != 0 && !hold_send &&
                    $urandom_range(1, 100) > send_idle_pct) begin
                in_ch.valid   <= 1'b1;
                in_ch.payload <= pending_rot.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_q;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_quat.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_ch.payload);
                    errors++;
                end else begin
                    exp_q = expected_quat.pop_front();
                    if (out_ch.payload !== exp_q) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, exp_q, out_ch.payload);
                        errors++;
                    end
                end
            end
            out_ch.ready <= $urandom_range(1, 100) > recv_stall_pct;
        end
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int mode;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_rot.push_back(make_rot(16'h1000, 0, 0, 0, 16'h1000, 0));
        pending_rot.push_back(make_rot(0, 0, 0, 0, 0, 0));
        pending_rot.push_back(make_rot(16'h1000, 0, 0, 16'h2000, 0, 0));
        pending_rot.push_back(make_rot(16'h8000, 16'h8000, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000));
        pending_rot.push_back(make_rot(16'h7fff, 16'h7fff, 16'h7fff,
                                       16'h8000, 16'h8000, 16'h8000));
        pending_rot.push_back(make_rot(16'h7fff, 16'h8000, 16'h7fff,
                                       16'h8000, 16'h7fff, 16'h8000));
        pending_rot.push_back(make_rot(16'hf000, 0, 0, 0, 16'hf000, 0));
        pending_rot.push_back(make_rot(16'h1000, 0, 0, 0, 16'hf000, 0));
        pending_rot.push_back(make_rot(16'hf000, 0, 0, 0, 16'h1000, 0));
        pending_rot.push_back(make_rot(0, 16'h1000, 0, 16'h1000, 0, 0));
        pending_rot.push_back(make_rot(0, 0, 16'h1000, 16'h1000, 0, 0));
        pending_rot.push_back(make_rot(0, 0, 1, 1, 0, 0));
        pending_rot.push_back(make_rot(1, 0, 0, 0, 1, 0));
        pending_rot.push_back(make_rot(16'h7fff, 0, 0, 0, 16'h7fff, 0));
        pending_rot.push_back(make_rot(16'h8000, 0, 0, 0, 16'h7fff, 16'h8000));
        pending_rot.push_back(make_rot(16'hffff, 16'hffff, 16'hffff,
                                       16'hffff, 1, 16'hffff));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 160; n++) begin
                mode = $urandom_range(0, 3);
                pending_rot.push_back(make_rot(rand_comp(mode), rand_comp(mode),
                    rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode)));
            end
            while (pending_rot.size() != 0) @(posedge i_clk);
            if (ph == 2) begin
                hold_send = 1;
                while (expected_quat.size() != 0 || in_ch.valid) @(posedge i_clk);
                hold_send = 0;
            end
        end

        while (in_ch.valid) @(posedge i_clk);
        while (expected_quat.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
